>>> sv/v2mc_pkg.sv
// Package for the 2D vector length clamp: action codes, config indexes,
// pipeline stage indexes and the per-stage record type. No dependencies.
package v2mc_pkg;

    typedef enum logic [1:0] {
        ACT_NONE  = 2'd0,
        ACT_MIN   = 2'd1,
        ACT_MAX   = 2'd2,
        ACT_ZERO  = 2'd3
    } t_action;

    localparam logic [7:0] CFG_MIN_LEN = 8'd0;
    localparam logic [7:0] CFG_MAX_LEN = 8'd1;

    localparam int ST_ABS    = 1;
    localparam int ST_SQUARE = 2;
    localparam int ST_SUM    = 3;
    localparam int ST_CMP    = 4;
    localparam int ST_SQRT0  = 5;
    localparam int ST_PROD   = ST_SQRT0 + 32;
    localparam int ST_NUM    = ST_PROD + 1;
    localparam int ST_DIV0   = ST_NUM + 1;
    localparam int ST_OUT    = ST_DIV0 + 32;
    localparam int ST_LAST   = ST_OUT;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] ax;
        logic [31:0] ay;
        logic        nx;
        logic        ny;
        logic [62:0] sqx;
        logic [62:0] sqy;
        logic [63:0] ll;
        logic [30:0] bound;
        t_action     action;
        logic        pass;
        logic        zero;
        logic [33:0] srem;
        logic [31:0] root;
        logic [62:0] numx;
        logic [62:0] numy;
        logic [32:0] dremx;
        logic [32:0] dremy;
        logic [31:0] qx;
        logic [31:0] qy;
        logic [31:0] ox;
        logic [31:0] oy;
        logic        sat;
    } t_stage;

endpackage

>>> sv/vector2_magnitude_clamp.sv
// Top level of the 2D vector length clamp: a 72-stage pipeline.
// Depends on v2mc_pkg for the stage record, action codes and stage indexes.
//
// Usage: each input transaction carries one vector (i_vec_x, i_vec_y) in
// signed Q16.16. Each produces exactly one output transaction with the
// vector rescaled so that its length lies between min_len and max_len
// (a zero vector stays zero), an action code and a saturation flag. The
// bounds are written through the configuration channel (index 0 min_len,
// 1 max_len, low 31 bits kept), which is always ready; write them only
// while the pipeline is empty, and allow one cycle before the next vector
// for the squared bounds to settle. One vector is accepted every cycle
// unless the output is stalled: the square root takes one result bit per
// stage over 32 stages, and the divider one quotient bit per stage over
// another 32, so neither iterates in place. When the receiver holds
// i_ready low while a result is shown, the whole pipeline freezes and
// o_ready drops; nothing is lost or repeated. Reset clears every stage
// valid bit and sets min_len to 0 and max_len to its largest value.
module vector2_magnitude_clamp (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_vec_x,
    input  logic [31:0] i_vec_y,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_out_x,
    output logic [31:0] o_out_y,
    output logic [1:0]  o_action,
    output logic        o_saturated,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam int NST = v2mc_pkg::ST_LAST + 1;

    logic [30:0]       r_min_len;
    logic [30:0]       r_max_len;
    logic [61:0]       r_min_sq;
    logic [61:0]       r_max_sq;
    logic [NST-1:0]    r_vld;
    v2mc_pkg::t_stage  r_p [NST];
    v2mc_pkg::t_stage  n_p [NST];
    logic              w_en;

    assign w_en        = !r_vld[NST-1] || i_ready;
    assign o_ready     = w_en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_len <= '0;
            r_max_len <= '1;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == v2mc_pkg::CFG_MIN_LEN) begin
                r_min_len <= i_cfg_data[30:0];
            end else if (i_cfg_index == v2mc_pkg::CFG_MAX_LEN) begin
                r_max_len <= i_cfg_data[30:0];
            end
        end
    end

    // The squared bounds are registered, following the bound registers in the next cycle.
    always_ff @(posedge i_clk) begin
        r_min_sq <= 62'(r_min_len) * 62'(r_min_len);
        r_max_sq <= 62'(r_max_len) * 62'(r_max_len);
    end

    always_comb begin
        logic [33:0] t_s;
        logic [33:0] trial;
        logic [32:0] tx;
        logic [32:0] ty;
        logic [63:0] px;
        logic [63:0] py;
        int          k;
        n_p[0]   = r_p[0];
        n_p[0].x = i_vec_x;
        n_p[0].y = i_vec_y;
        for (int s = 1; s < NST; s++) begin
            n_p[s] = r_p[s-1];
            t_s   = '0;
            trial = '0;
            tx    = '0;
            ty    = '0;
            px    = '0;
            py    = '0;
            k     = 0;
            if (s == v2mc_pkg::ST_ABS) begin
                n_p[s].nx = r_p[s-1].x[31];
                n_p[s].ny = r_p[s-1].y[31];
                n_p[s].ax = r_p[s-1].x[31] ? (32'd0 - r_p[s-1].x) : r_p[s-1].x;
                n_p[s].ay = r_p[s-1].y[31] ? (32'd0 - r_p[s-1].y) : r_p[s-1].y;
            end else if (s == v2mc_pkg::ST_SQUARE) begin
                px = 64'(r_p[s-1].ax) * 64'(r_p[s-1].ax);
                py = 64'(r_p[s-1].ay) * 64'(r_p[s-1].ay);
                n_p[s].sqx = px[62:0];
                n_p[s].sqy = py[62:0];
            end else if (s == v2mc_pkg::ST_SUM) begin
                n_p[s].ll = 64'(r_p[s-1].sqx) + 64'(r_p[s-1].sqy);
            end else if (s == v2mc_pkg::ST_CMP) begin
                n_p[s].zero   = (r_p[s-1].ll == 64'd0);
                n_p[s].pass   = 1'b0;
                n_p[s].srem   = '0;
                n_p[s].root   = '0;
                n_p[s].bound  = r_min_len;
                n_p[s].action = v2mc_pkg::ACT_MIN;
                if (r_p[s-1].ll < 64'(r_min_sq)) begin
                    n_p[s].bound  = r_min_len;
                    n_p[s].action = v2mc_pkg::ACT_MIN;
                end else if (r_p[s-1].ll > 64'(r_max_sq)) begin
                    n_p[s].bound  = r_max_len;
                    n_p[s].action = v2mc_pkg::ACT_MAX;
                end else begin
                    n_p[s].pass   = 1'b1;
                    n_p[s].action = v2mc_pkg::ACT_NONE;
                end
            end else if (s >= v2mc_pkg::ST_SQRT0 && s < v2mc_pkg::ST_PROD) begin
                // One root bit per stage, taking two bits of the square.
                k     = s - v2mc_pkg::ST_SQRT0;
                t_s   = {r_p[s-1].srem[31:0], r_p[s-1].ll[63-2*k -: 2]};
                trial = {r_p[s-1].root, 2'b01};
                if (t_s >= trial) begin
                    n_p[s].srem = t_s - trial;
                    n_p[s].root = {r_p[s-1].root[30:0], 1'b1};
                end else begin
                    n_p[s].srem = t_s;
                    n_p[s].root = {r_p[s-1].root[30:0], 1'b0};
                end
            end else if (s == v2mc_pkg::ST_PROD) begin
                px = 64'(r_p[s-1].ax) * 64'(r_p[s-1].bound);
                py = 64'(r_p[s-1].ay) * 64'(r_p[s-1].bound);
                n_p[s].sqx = px[62:0];
                n_p[s].sqy = py[62:0];
            end else if (s == v2mc_pkg::ST_NUM) begin
                n_p[s].numx  = r_p[s-1].sqx + 63'(r_p[s-1].root[31:1]);
                n_p[s].numy  = r_p[s-1].sqy + 63'(r_p[s-1].root[31:1]);
                n_p[s].dremx = 33'(n_p[s].numx[62:32]);
                n_p[s].dremy = 33'(n_p[s].numy[62:32]);
                n_p[s].qx    = '0;
                n_p[s].qy    = '0;
            end else if (s >= v2mc_pkg::ST_DIV0 && s < v2mc_pkg::ST_OUT) begin
                // Restoring division, one quotient bit per stage per lane.
                k  = s - v2mc_pkg::ST_DIV0;
                tx = {r_p[s-1].dremx[31:0], r_p[s-1].numx[31-k]};
                ty = {r_p[s-1].dremy[31:0], r_p[s-1].numy[31-k]};
                if (tx >= {1'b0, r_p[s-1].root}) begin
                    n_p[s].dremx     = tx - {1'b0, r_p[s-1].root};
                    n_p[s].qx[31-k]  = 1'b1;
                end else begin
                    n_p[s].dremx = tx;
                end
                if (ty >= {1'b0, r_p[s-1].root}) begin
                    n_p[s].dremy     = ty - {1'b0, r_p[s-1].root};
                    n_p[s].qy[31-k]  = 1'b1;
                end else begin
                    n_p[s].dremy = ty;
                end
            end else if (s == v2mc_pkg::ST_OUT) begin
                n_p[s].sat = 1'b0;
                if (r_p[s-1].pass) begin
                    n_p[s].ox = r_p[s-1].x;
                    n_p[s].oy = r_p[s-1].y;
                end else if (r_p[s-1].zero) begin
                    n_p[s].ox     = '0;
                    n_p[s].oy     = '0;
                    n_p[s].action = v2mc_pkg::ACT_ZERO;
                end else begin
                    if (!r_p[s-1].nx) begin
                        n_p[s].ox = r_p[s-1].qx;
                        if (r_p[s-1].qx > 32'h7FFF_FFFF) begin
                            n_p[s].ox  = 32'h7FFF_FFFF;
                            n_p[s].sat = 1'b1;
                        end
                    end else if (r_p[s-1].qx > 32'h8000_0000) begin
                        n_p[s].ox  = 32'h8000_0000;
                        n_p[s].sat = 1'b1;
                    end else begin
                        n_p[s].ox = 32'd0 - r_p[s-1].qx;
                    end
                    if (!r_p[s-1].ny) begin
                        n_p[s].oy = r_p[s-1].qy;
                        if (r_p[s-1].qy > 32'h7FFF_FFFF) begin
                            n_p[s].oy  = 32'h7FFF_FFFF;
                            n_p[s].sat = 1'b1;
                        end
                    end else if (r_p[s-1].qy > 32'h8000_0000) begin
                        n_p[s].oy  = 32'h8000_0000;
                        n_p[s].sat = 1'b1;
                    end else begin
                        n_p[s].oy = 32'd0 - r_p[s-1].qy;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NST-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int s = 0; s < NST; s++) begin
                r_p[s] <= n_p[s];
            end
        end
    end

    assign o_valid     = r_vld[NST-1];
    assign o_out_x     = r_p[NST-1].ox;
    assign o_out_y     = r_p[NST-1].oy;
    assign o_action    = r_p[NST-1].action;
    assign o_saturated = r_p[NST-1].sat;

    a_pass_no_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_action == v2mc_pkg::ACT_NONE || o_action == v2mc_pkg::ACT_ZERO)
        |-> !o_saturated)
        else $error("saturation flagged on a vector that was not rescaled");

    a_zero_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_action == v2mc_pkg::ACT_ZERO |-> o_out_x == 32'd0 && o_out_y == 32'd0)
        else $error("zero-vector result is not zero");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("pipeline not empty after reset");

    a_stall_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |-> !o_ready)
        else $error("input taken while the output stage is stalled");

endmodule
